@@ hw/rtl/ray_sphere_intersection_defines.svh @@
// ----------------------------------------------------------------------------
// Ray-sphere intersection assertion macros
// Shared property wrappers, all clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECTION_DEFINES_SVH
`define RAY_SPHERE_INTERSECTION_DEFINES_SVH

// Same-cycle implication.
`define RSI_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RSI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// Ray-sphere intersection package
// Widths, reset values and the per-cell record of the square-root chain.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int FRAC_BITS = 16;

  localparam int COORD_W = 32;
  localparam int DIR_W   = 18;
  localparam int RAD_W   = 31;
  localparam int DIST_W  = 31;

  localparam int DIFF_W = COORD_W + 1;
  localparam int LD_W   = DIFF_W + DIR_W;
  localparam int LSQ_W  = 2 * DIFF_W - 1;
  localparam int R2_W   = 2 * RAD_W;
  localparam int TCA_W  = LD_W + 1;
  localparam int MAG_W  = TCA_W - 1;
  localparam int LO_W   = 32;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int LL_W   = LSQ_W + 1;

  // Radicand at 4F fraction bits; kept even so the root has exactly half.
  localparam int DISC_W = (FRAC_BITS > 19) ? 2 * FRAC_BITS + 66 : 104;
  localparam int ROOT_W = DISC_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int EPS_W  = RAD_W + FRAC_BITS;
  localparam int T_W    = ROOT_W + 2;

  localparam logic [RAD_W-1:0]  MIN_DIST_RESET = RAD_W'(66);
  localparam logic [DIST_W-1:0] DIST_MAX       = {DIST_W{1'b1}};

  typedef struct packed {
    logic                     valid;
    logic                     miss;
    logic signed [TCA_W-1:0]  tca;
    logic        [DISC_W-1:0] disc;
    logic        [REM_W-1:0]  rem;
    logic        [ROOT_W-1:0] root;
  } cell_t;

endpackage

@@ hw/rtl/rsi_ifs.sv @@
// ----------------------------------------------------------------------------
// Ray-sphere intersection channels
// Valid/ready interfaces for ray beats and result beats.
// ----------------------------------------------------------------------------
interface rsi_ray_if;
  logic                              valid;
  logic                              ready;
  logic signed [rsi_pkg::COORD_W-1:0] origin_x;
  logic signed [rsi_pkg::COORD_W-1:0] origin_y;
  logic signed [rsi_pkg::COORD_W-1:0] origin_z;
  logic signed [rsi_pkg::DIR_W-1:0]   dir_x;
  logic signed [rsi_pkg::DIR_W-1:0]   dir_y;
  logic signed [rsi_pkg::DIR_W-1:0]   dir_z;
  logic signed [rsi_pkg::COORD_W-1:0] center_x;
  logic signed [rsi_pkg::COORD_W-1:0] center_y;
  logic signed [rsi_pkg::COORD_W-1:0] center_z;
  logic        [rsi_pkg::RAD_W-1:0]   sphere_radius;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  center_x, center_y, center_z, sphere_radius, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                center_x, center_y, center_z, sphere_radius, output ready);
endinterface

interface rsi_hit_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [rsi_pkg::DIST_W-1:0]       hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink (input valid, hit, hit_distance, output ready);
endinterface

@@ hw/rtl/ray_sphere_intersection.sv @@
// ----------------------------------------------------------------------------
// Ray-sphere intersection
// Geometric ray-sphere test in signed Q16.16 with a pipelined square root.
// ----------------------------------------------------------------------------
// Usage: ray beats arrive on the ray channel (origin, unit direction, sphere
// center and radius) and one result beat per ray leaves on the result channel
// (hit flag and distance along the ray, zero on a miss).
// Throughput is one ray per cycle while the skid entry is empty. An accepted
// ray beat passes through seven front-end stages, one square root cell per
// root bit (52 cells), the crossing select and the output register before
// its result beat is shown. The square-root chain is what sets the depth.
// The epsilon min_distance is written through cfg_write_en/cfg_write_data and
// should only change while no ray is in flight.
// Reset clears all valid flags and loads the epsilon with its default.
// When the receiver stalls, one further result lands in a skid entry and the
// whole pipeline then freezes, dropping ray.ready until the skid drains.
// ----------------------------------------------------------------------------
module ray_sphere_intersection (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [rsi_pkg::RAD_W-1:0] cfg_write_data,
  rsi_ray_if.sink                   ray,
  rsi_hit_if.source                 result
);

  logic [rsi_pkg::RAD_W-1:0] min_distance;
  logic                      en;

  // Chain of records, one per square-root cell boundary.
  rsi_pkg::cell_t chain [rsi_pkg::ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= rsi_pkg::MIN_DIST_RESET;
    end else if (cfg_write_en) begin
      min_distance <= cfg_write_data;
    end
  end

  // The whole pipeline advances together; a ray is taken whenever it moves.
  assign ray.ready = en;

  rsi_front u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .ray  (ray),
    .head (chain[0])
  );

  // Each cell settles one root bit, most significant first.
  for (genvar i = 0; i < rsi_pkg::ROOT_W; i++) begin : g_cell
    rsi_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (chain[i]),
      .cur  (chain[i+1])
    );
  end

  rsi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fin          (chain[rsi_pkg::ROOT_W]),
    .min_distance (min_distance),
    .en           (en),
    .result       (result)
  );

endmodule

@@ hw/rtl/rsi_front.sv @@
// ----------------------------------------------------------------------------
// Ray-sphere front end
// Seven stages: center offset, products, dot sums, split square of the
// projection, radicand sum, and the miss test with the radicand difference.
// ----------------------------------------------------------------------------
module rsi_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  rsi_ray_if.sink        ray,
  output rsi_pkg::cell_t head
);

  logic signed [rsi_pkg::COORD_W-1:0] org [3];
  logic signed [rsi_pkg::COORD_W-1:0] ctr [3];
  logic signed [rsi_pkg::DIR_W-1:0]   dir [3];

  logic [5:0] vld;

  logic signed [rsi_pkg::DIFF_W-1:0] l1 [3];
  logic signed [rsi_pkg::DIR_W-1:0]  d1 [3];
  logic        [rsi_pkg::RAD_W-1:0]  rad1;

  logic signed [rsi_pkg::LD_W-1:0]  ld2 [3];
  logic        [rsi_pkg::LSQ_W-1:0] lsq2 [3];
  logic        [rsi_pkg::R2_W-1:0]  r2_2;

  logic signed [rsi_pkg::TCA_W-1:0] tca3;
  logic        [rsi_pkg::LL_W-1:0]  ll3;
  logic        [rsi_pkg::R2_W-1:0]  r2_3;

  logic        [rsi_pkg::MAG_W-1:0]         mag3;
  logic signed [rsi_pkg::TCA_W-1:0]         tca4;
  logic        [2*rsi_pkg::HI_W-1:0]        pp_hh4;
  logic        [rsi_pkg::HI_W+rsi_pkg::LO_W-1:0] pp_hl4;
  logic        [2*rsi_pkg::LO_W-1:0]        pp_ll4;
  logic        [rsi_pkg::LL_W-1:0]          ll4;
  logic        [rsi_pkg::R2_W-1:0]          r2_4;

  logic signed [rsi_pkg::TCA_W-1:0]  tca5;
  logic        [rsi_pkg::DISC_W-1:0] tc2_5;
  logic        [rsi_pkg::DISC_W-1:0] r2s5;
  logic        [rsi_pkg::DISC_W-1:0] lls5;

  logic signed [rsi_pkg::TCA_W-1:0]  tca6;
  logic        [rsi_pkg::DISC_W-1:0] a6;
  logic        [rsi_pkg::DISC_W-1:0] lls6;

  logic [rsi_pkg::DISC_W:0] diff6;

  assign org = '{ray.origin_x, ray.origin_y, ray.origin_z};
  assign ctr = '{ray.center_x, ray.center_y, ray.center_z};
  assign dir = '{ray.dir_x, ray.dir_y, ray.dir_z};

  assign mag3  = rsi_pkg::MAG_W'(tca3[rsi_pkg::TCA_W-1] ? -tca3 : tca3);
  // The borrow out of the subtract is the miss flag.
  assign diff6 = {1'b0, a6} - {1'b0, lls6};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], ray.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        l1[i]   <= $signed({ctr[i][rsi_pkg::COORD_W-1], ctr[i]})
                 - $signed({org[i][rsi_pkg::COORD_W-1], org[i]});
        d1[i]   <= dir[i];
        ld2[i]  <= l1[i] * d1[i];
        lsq2[i] <= rsi_pkg::LSQ_W'(l1[i] * l1[i]);
      end
      rad1   <= ray.sphere_radius;
      r2_2   <= rad1 * rad1;

      tca3   <= ld2[0] + ld2[1] + ld2[2];
      ll3    <= rsi_pkg::LL_W'(lsq2[0]) + rsi_pkg::LL_W'(lsq2[1])
              + rsi_pkg::LL_W'(lsq2[2]);
      r2_3   <= r2_2;

      tca4   <= tca3;
      pp_hh4 <= mag3[rsi_pkg::MAG_W-1:rsi_pkg::LO_W] * mag3[rsi_pkg::MAG_W-1:rsi_pkg::LO_W];
      pp_hl4 <= mag3[rsi_pkg::MAG_W-1:rsi_pkg::LO_W] * mag3[rsi_pkg::LO_W-1:0];
      pp_ll4 <= mag3[rsi_pkg::LO_W-1:0] * mag3[rsi_pkg::LO_W-1:0];
      ll4    <= ll3;
      r2_4   <= r2_3;

      tca5   <= tca4;
      tc2_5  <= (rsi_pkg::DISC_W'(pp_hh4) << (2 * rsi_pkg::LO_W))
              + (rsi_pkg::DISC_W'(pp_hl4) << (rsi_pkg::LO_W + 1))
              + rsi_pkg::DISC_W'(pp_ll4);
      r2s5   <= rsi_pkg::DISC_W'(r2_4) << (2 * rsi_pkg::FRAC_BITS);
      lls5   <= rsi_pkg::DISC_W'(ll4) << (2 * rsi_pkg::FRAC_BITS);

      tca6   <= tca5;
      a6     <= tc2_5 + r2s5;
      lls6   <= lls5;

      head.tca  <= tca6;
      head.miss <= diff6[rsi_pkg::DISC_W];
      head.disc <= diff6[rsi_pkg::DISC_W-1:0];
      head.rem  <= '0;
      head.root <= '0;
    end
    if (rst) begin
      head.valid <= 1'b0;
    end else if (en) begin
      head.valid <= vld[5];
    end
  end

endmodule

@@ hw/rtl/rsi_cell.sv @@
// ----------------------------------------------------------------------------
// Square-root cell
// One restoring step: brings in two radicand bits and settles one root bit.
// ----------------------------------------------------------------------------
module rsi_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  rsi_pkg::cell_t prev,
  output rsi_pkg::cell_t cur
);

  logic [rsi_pkg::REM_W-1:0] rem_sh;
  logic [rsi_pkg::REM_W-1:0] trial;
  logic                      take;

  assign rem_sh = {prev.rem[rsi_pkg::REM_W-3:0],
                   prev.disc[rsi_pkg::DISC_W-1:rsi_pkg::DISC_W-2]};
  assign trial  = rsi_pkg::REM_W'({prev.root, 2'b01});
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      cur.miss <= prev.miss;
      cur.tca  <= prev.tca;
      cur.disc <= {prev.disc[rsi_pkg::DISC_W-3:0], 2'b00};
      cur.rem  <= take ? rem_sh - trial : rem_sh;
      cur.root <= {prev.root[rsi_pkg::ROOT_W-2:0], take};
    end
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur.valid <= prev.valid;
    end
  end

endmodule

@@ hw/rtl/rsi_back.sv @@
// ----------------------------------------------------------------------------
// Ray-sphere back end
// Picks the near or far crossing against the epsilon, then an output
// register with a skid entry drives the result channel.
// ----------------------------------------------------------------------------
module rsi_back (
  input  logic                       clk,
  input  logic                       rst,
  input  rsi_pkg::cell_t             fin,
  input  logic [rsi_pkg::RAD_W-1:0]  min_distance,
  output logic                       en,
  rsi_hit_if.source                  result
);

  logic signed [rsi_pkg::T_W-1:0] tca_x;
  logic signed [rsi_pkg::T_W-1:0] root_x;
  logic signed [rsi_pkg::T_W-1:0] eps;
  logic signed [rsi_pkg::T_W-1:0] t0;
  logic signed [rsi_pkg::T_W-1:0] t1;
  logic signed [rsi_pkg::T_W-1:0] t_sel;
  logic                           near_ok;
  logic                           far_ok;
  logic [rsi_pkg::DIST_W-1:0]     dist_sat;

  logic                       p_valid;
  logic                       p_hit;
  logic [rsi_pkg::DIST_W-1:0] p_dist;
  logic                       skid_valid;
  logic                       skid_hit;
  logic [rsi_pkg::DIST_W-1:0] skid_dist;

  assign tca_x  = $signed({{(rsi_pkg::T_W-rsi_pkg::TCA_W){fin.tca[rsi_pkg::TCA_W-1]}}, fin.tca});
  assign root_x = $signed({{(rsi_pkg::T_W-rsi_pkg::ROOT_W){1'b0}}, fin.root});
  assign eps    = $signed(rsi_pkg::T_W'(min_distance) << rsi_pkg::FRAC_BITS);
  assign t0     = tca_x - root_x;
  assign t1     = tca_x + root_x;
  assign near_ok = t0 > eps;
  assign far_ok  = t1 > eps;
  assign t_sel   = near_ok ? t0 : t1;
  assign dist_sat = (|t_sel[rsi_pkg::T_W-1:rsi_pkg::FRAC_BITS+rsi_pkg::DIST_W])
                  ? rsi_pkg::DIST_MAX
                  : t_sel[rsi_pkg::FRAC_BITS+rsi_pkg::DIST_W-1:rsi_pkg::FRAC_BITS];

  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (en) begin
      p_hit  <= !fin.miss && (near_ok || far_ok);
      p_dist <= (!fin.miss && (near_ok || far_ok)) ? dist_sat : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      skid_valid   <= 1'b0;
      result.valid <= 1'b0;
    end else if (!skid_valid) begin
      p_valid <= fin.valid;
      if (result.ready || !result.valid) begin
        result.valid <= p_valid;
      end else if (p_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (result.ready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      if (result.ready || !result.valid) begin
        result.hit          <= p_hit;
        result.hit_distance <= p_dist;
      end else begin
        skid_hit  <= p_hit;
        skid_dist <= p_dist;
      end
    end else if (result.ready) begin
      result.hit          <= skid_hit;
      result.hit_distance <= skid_dist;
    end
  end

endmodule

@@ hw/rtl/rsi_checker.sv @@
// ----------------------------------------------------------------------------
// Ray-sphere intersection port checker
// Watches the top-level channels for stall and miss behavior.
// ----------------------------------------------------------------------------
`include "ray_sphere_intersection_defines.svh"

module rsi_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       hit,
  input logic [rsi_pkg::DIST_W-1:0] hit_distance
);

  `RSI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `RSI_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(hit) && $stable(hit_distance), "result changed while stalled")
  `RSI_ASSERT_IMPLY(a_miss_zero, out_valid && !hit, hit_distance == '0, "miss with nonzero distance")
  `RSI_ASSERT_IMPLY(a_backpressure, !in_ready, out_valid, "ray channel blocked with no result waiting")

endmodule

bind ray_sphere_intersection rsi_checker u_rsi_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (ray.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .hit          (result.hit),
  .hit_distance (result.hit_distance)
);

@@ verif/rsi_tb_ifs.sv @@
// ----------------------------------------------------------------------------
// Ray-sphere intersection test channels
// Testbench copies are not needed; the RTL interfaces are used directly.
// This file only groups the beat record types shared by the bench.
// ----------------------------------------------------------------------------
package rsi_tb_pkg;
  import rsi_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] ox, oy, oz;
    logic signed [DIR_W-1:0]   dx, dy, dz;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic        [RAD_W-1:0]   rad;
  } ray_beat_t;

  typedef struct {
    logic              hit;
    logic [DIST_W-1:0] distance;
  } hit_beat_t;
endpackage

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Ray-sphere intersection testbench
// Drives ray beats through the block under random source gaps and sink
// stalls, predicts each result with an exact wide-integer model of the
// geometric test, and compares result beats in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsi_pkg::*;
  import rsi_tb_pkg::*;

  // Exact geometric hit predictor. All arithmetic is done in signed 200-bit
  // integers so that no intermediate ever overflows; the only roundings are the
  // floor square root and the truncated distance, matching the block's definition.
  class hit_scoreboard;
    hit_beat_t   pending[$];
    logic [RAD_W-1:0] epsilon;
    int          errors;
    int          checked;
    int          hits;

    function new();
      epsilon = MIN_DIST_RESET;
      errors  = 0;
      checked = 0;
      hits    = 0;
    endfunction

    // Floor square root of a non-negative value, one bit at a time.
    function automatic logic [63:0] isqrt(logic signed [199:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
        c = r | (64'd1 << i);
        if ($signed({136'd0, c}) * $signed({136'd0, c}) <= v) r = c;
      end
      return r;
    endfunction

    function automatic hit_beat_t predict(ray_beat_t b);
      logic signed [199:0] l[3];
      logic signed [199:0] tca, ll, r2, disc, thc, t0, t1, eps, tsel;
      hit_beat_t res;
      l[0] = $signed(b.cx) - $signed(b.ox);
      l[1] = $signed(b.cy) - $signed(b.oy);
      l[2] = $signed(b.cz) - $signed(b.oz);
      tca = l[0] * $signed(b.dx) + l[1] * $signed(b.dy) + l[2] * $signed(b.dz);
      ll = (l[0] * l[0] + l[1] * l[1] + l[2] * l[2]) <<< (2 * FRAC_BITS);
      r2 = ($signed({169'd0, b.rad}) * $signed({169'd0, b.rad})) <<< (2 * FRAC_BITS);
      res.hit      = 1'b0;
      res.distance = '0;
      if (ll > r2 + tca * tca) return res;
      disc = r2 + tca * tca - ll;
      thc  = $signed({136'd0, isqrt(disc)});
      t0   = tca - thc;
      t1   = tca + thc;
      eps  = $signed({169'd0, epsilon}) <<< FRAC_BITS;
      if (t0 > eps) tsel = t0;
      else if (t1 > eps) tsel = t1;
      else return res;
      tsel = tsel >>> FRAC_BITS;
      res.hit      = 1'b1;
      res.distance = (tsel > 200'sh7FFFFFFF) ? DIST_MAX : tsel[DIST_W-1:0];
      return res;
    endfunction

    function void note_ray(ray_beat_t b);
      pending.push_back(predict(b));
    endfunction

    function void check_hit(hit_beat_t got);
      hit_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing expected: hit=%0d dist=%0d",
                 $realtime, got.hit, got.distance);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.hit) hits++;
      if (got.hit !== want.hit) begin
        $display("%0t: hit mismatch: expected %0d actual %0d",
                 $realtime, want.hit, got.hit);
        errors++;
      end
      if (got.distance !== want.distance) begin
        $display("%0t: hit_distance mismatch: expected %0d actual %0d",
                 $realtime, want.distance, got.distance);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY   = 60;
  localparam int MAX_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [RAD_W-1:0] cfg_write_data = '0;

  rsi_ray_if ray ();
  rsi_hit_if result ();

  ray_sphere_intersection uut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .ray(ray.sink),
    .result(result.source)
  );

  always #1 clk = ~clk;

  hit_scoreboard board = new();
  int cycles = 0;
  int send_idle_pct = 0;  // chance that the sender idles in a cycle
  int sink_stall_pct = 0; // chance that the receiver stalls in a cycle

  initial begin
    ray.valid = 1'b0;
    ray.origin_x = '0; ray.origin_y = '0; ray.origin_z = '0;
    ray.dir_x = '0; ray.dir_y = '0; ray.dir_z = '0;
    ray.center_x = '0; ray.center_y = '0; ray.center_z = '0;
    ray.sphere_radius = '0;
    result.ready = 1'b0;
  end

  // Watchdog: the slowest correct run is far below this bound.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver: ready is redrawn at every falling edge, results are taken at
  // the rising edge.
  always @(negedge clk)
    if (!rst) result.ready <= ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk)
    if (!rst && result.valid && result.ready) begin
      hit_beat_t got;
      got.hit      = result.hit;
      got.distance = result.hit_distance;
      board.check_hit(got);
    end

  // Send one ray beat: hold it until the block takes it at a rising edge.
  task automatic send_ray(ray_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      ray.valid <= 1'b0;
      @(negedge clk);
    end
    ray.valid <= 1'b1;
    ray.origin_x <= b.ox; ray.origin_y <= b.oy; ray.origin_z <= b.oz;
    ray.dir_x <= b.dx; ray.dir_y <= b.dy; ray.dir_z <= b.dz;
    ray.center_x <= b.cx; ray.center_y <= b.cy; ray.center_z <= b.cz;
    ray.sphere_radius <= b.rad;
    do @(posedge clk); while (!ray.ready);
    board.note_ray(b);
    @(negedge clk);
  endtask

  // Drop valid and wait for the pipeline to empty before a register write.
  task automatic drain();
    ray.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic write_epsilon(logic [RAD_W-1:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    board.epsilon = v;
  endtask

  // A random direction component: within +/-1.0, exactly +/-1.0, small, or raw.
  function automatic logic signed [DIR_W-1:0] rand_dir();
    case ($urandom_range(3))
      0: return DIR_W'($urandom_range(131072) - 65536);
      1: return ($urandom_range(1)) ? 18'sd65536 : -18'sd65536;
      2: return DIR_W'($urandom_range(2000) - 1000);
      default: return DIR_W'($urandom);
    endcase
  endfunction

  // Most rays are built to hit: the center is placed ahead along the ray
  // at a small offset, with a radius drawn on the same scale.
  function automatic ray_beat_t rand_ray();
    ray_beat_t b;
    int scale;
    b.dx = rand_dir(); b.dy = rand_dir(); b.dz = rand_dir();
    if ($urandom_range(9) < 2) begin
      b.ox = $urandom; b.oy = $urandom; b.oz = $urandom;
      b.cx = $urandom; b.cy = $urandom; b.cz = $urandom;
      b.rad = $urandom;
    end else begin
      scale = $urandom_range(24, 8);
      b.ox = $signed($urandom) >>> $urandom_range(31, 8);
      b.oy = $signed($urandom) >>> $urandom_range(31, 8);
      b.oz = $signed($urandom) >>> $urandom_range(31, 8);
      b.cx = b.ox + ((b.dx * $signed(32'($urandom_range(1 << scale)))) >>> 16)
             + $signed($urandom_range(4000) - 2000);
      b.cy = b.oy + ((b.dy * $signed(32'($urandom_range(1 << scale)))) >>> 16)
             + $signed($urandom_range(4000) - 2000);
      b.cz = b.oz + ((b.dz * $signed(32'($urandom_range(1 << scale)))) >>> 16)
             + $signed($urandom_range(4000) - 2000);
      b.rad = RAD_W'($urandom_range(1 << scale));
    end
    return b;
  endfunction

  function automatic ray_beat_t make_ray(int ox, int cx, int dx, int rad);
    ray_beat_t b;
    b.ox = ox; b.oy = 0; b.oz = 0;
    b.dx = DIR_W'(dx); b.dy = 0; b.dz = 0;
    b.cx = cx; b.cy = 0; b.cz = 0;
    b.rad = RAD_W'(rad);
    return b;
  endfunction

  initial begin
    ray_beat_t b;
    int phase_pct[4][2] = '{'{0, 0}, '{61, 0}, '{0, 61}, '{7, 7}};
    logic [RAD_W-1:0] eps_set[4] = '{RAD_W'(0), DIST_MAX, RAD_W'(66), RAD_W'(65536)};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed beats at the reset epsilon: sphere ahead, origin inside the
    // sphere, sphere behind, a tangent ray, a clear miss, a crossing right
    // at the epsilon, and saturating extremes.
    send_ray(make_ray(0, 10 << 16, 65536, 2 << 16));
    send_ray(make_ray(0, 0, 65536, 3 << 16));
    send_ray(make_ray(0, -(10 << 16), 65536, 2 << 16));
    b = make_ray(0, 10 << 16, 65536, 1 << 16); b.cy = 1 << 16; send_ray(b);
    b = make_ray(0, 10 << 16, 65536, 1 << 16); b.cy = 5 << 16; send_ray(b);
    send_ray(make_ray(0, 66 + 5, 65536, 5));
    send_ray(make_ray(0, 66, 65536, 0));
    send_ray(make_ray(32'h80000000, 32'h7FFFFFFF, 65536, 32'h7FFFFFFF));
    send_ray(make_ray(32'h7FFFFFFF, 32'h80000000, -65536, 32'h7FFFFFFF));
    send_ray(make_ray(0, 10 << 16, 0, 32'h7FFFFFFF));
    b.ox = 32'h80000000; b.oy = 32'h80000000; b.oz = 32'h80000000;
    b.cx = 32'h7FFFFFFF; b.cy = 32'h7FFFFFFF; b.cz = 32'h7FFFFFFF;
    b.dx = 18'sh1FFFF; b.dy = 18'sh1FFFF; b.dz = 18'sh1FFFF; b.rad = DIST_MAX;
    send_ray(b);
    b.dx = 18'sh20000; b.dy = 18'sh20000; b.dz = 18'sh20000; b.rad = '0;
    send_ray(b);
    b = make_ray(0, 100 << 16, 65536, 1 << 16); b.dy = 65536; b.dz = -65536;
    send_ray(b);

    // Random phases, cycling through four idling patterns and epsilons; the last phase draws a random epsilon.
    for (int p = 0; p < 8; p++) begin
      drain();
      write_epsilon((p == 7) ? RAD_W'($urandom) : eps_set[p % 4]);
      send_idle_pct = phase_pct[p % 4][0];
      sink_stall_pct = phase_pct[p % 4][1];
      repeat (62) send_ray(rand_ray());
    end

    drain();
    $display("Checked %0d result beats (%0d hits) over eight idling/epsilon phases.",
             board.checked, board.hits);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
